// ===== rtl/sarsa_q_table_update_macros.svh =====
// Assertion macros shared by the SARSA value-table update block.
`ifndef SARSA_Q_TABLE_UPDATE_MACROS_SVH
`define SARSA_Q_TABLE_UPDATE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SQTU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When cond holds, prop must hold at the following clock edge.
`define SQTU_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/sqtu_pkg.sv =====
// Shared constants, types and helper functions of the SARSA value-table update block.
package sqtu_pkg;

   // Coarse grid geometry.
   localparam int COARSE_SIDE = 5;
   localparam int CELLS       = COARSE_SIDE * COARSE_SIDE;
   localparam int DEPTH       = CELLS * CELLS;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CELL_W      = $clog2(CELLS);
   localparam int CSIDE_W     = $clog2(COARSE_SIDE);

   // Field widths.
   localparam int FINE_W     = 12;
   localparam int VALUE_W    = 32;
   localparam int RATE_W     = 17;
   localparam int SIZE_W     = 7;
   localparam int OUT_CELL_W = 5;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Divider step counter.
   localparam int DIV_CNT_W = $clog2(FINE_W + 1);

   // Reciprocal of COARSE_SIDE used to derive the scale factors.
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP       = (2**RECIP_SHIFT + COARSE_SIDE - 1) / COARSE_SIDE;
   localparam int SCALE_PROD_W = 24;

   // Arithmetic widths.
   localparam int MUL_A_W    = 33;
   localparam int MUL_W      = MUL_A_W + RATE_W + 1;
   localparam int TARGET_W   = 34;
   localparam int DIFF_W     = 35;
   localparam int SPLIT_W    = 17;
   localparam int LO_PROD_W  = 34;
   localparam int HI_PROD_W  = 36;
   localparam int FULL_W     = HI_PROD_W + SPLIT_W;
   localparam int ROUND_W    = FULL_W - 16;
   localparam int NV_W       = ROUND_W + 1;

   // Register reset values.
   localparam logic [RATE_W-1:0] LEARN_RATE_RST  = 17'd6554;
   localparam logic [RATE_W-1:0] DISCOUNT_RST    = 17'd58982;
   localparam logic [SIZE_W-1:0] FINE_WIDTH_RST  = 7'd25;
   localparam logic [SIZE_W-1:0] FINE_HEIGHT_RST = 7'd25;

   // Register indexes.
   localparam logic [1:0] REG_LEARN_RATE  = 2'd0;
   localparam logic [1:0] REG_DISCOUNT    = 2'd1;
   localparam logic [1:0] REG_FINE_WIDTH  = 2'd2;
   localparam logic [1:0] REG_FINE_HEIGHT = 2'd3;

   // Positions of the four fine cells of one transaction.
   localparam logic [1:0] CELL_STATE       = 2'd0;
   localparam logic [1:0] CELL_ACTION      = 2'd1;
   localparam logic [1:0] CELL_NEXT_STATE  = 2'd2;
   localparam logic [1:0] CELL_NEXT_ACTION = 2'd3;

   // Multiplier operand selection.
   typedef logic [1:0] mul_sel_type;
   localparam mul_sel_type MUL_SEL_NEXT = 2'd0;
   localparam mul_sel_type MUL_SEL_LO   = 2'd1;
   localparam mul_sel_type MUL_SEL_HI   = 2'd2;

   typedef struct packed {
      logic [RATE_W-1:0] learn_rate;
      logic [RATE_W-1:0] discount;
      logic [SIZE_W-1:0] fine_width;
      logic [SIZE_W-1:0] fine_height;
   } cfg_type;

   typedef struct packed {
      logic        clr_step;
      logic        req_load;
      logic        div_load;
      logic        div_step;
      logic        cell_store;
      logic [1:0]  cell_idx;
      logic        rd_here;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        target_en;
      logic        diff_en;
      logic        sum_en;
      logic        commit;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_done;
   } status_type;

   // Low bits of a coarse cell as shown on the result channel.
   function automatic logic [OUT_CELL_W-1:0] out_cell(input logic [CELL_W-1:0] c);
      logic [31:0] wide;
      wide = 32'(c);
      return wide[OUT_CELL_W-1:0];
   endfunction

endpackage

// ===== rtl/sqtu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sqtu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 625
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/sqtu_ctrl.sv =====
// Controller state machine that sequences the clearing pass and each update.
module sqtu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sqtu_pkg::status_type status,
   output sqtu_pkg::cmd_type    cmd
);

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_DIV_LOAD = 4'd2;
   localparam logic [3:0] ST_DIV_RUN  = 4'd3;
   localparam logic [3:0] ST_CELL     = 4'd4;
   localparam logic [3:0] ST_RD_NEXT  = 4'd5;
   localparam logic [3:0] ST_RD_HERE  = 4'd6;
   localparam logic [3:0] ST_TARGET   = 4'd7;
   localparam logic [3:0] ST_DIFF     = 4'd8;
   localparam logic [3:0] ST_MUL_LO   = 4'd9;
   localparam logic [3:0] ST_MUL_HI   = 4'd10;
   localparam logic [3:0] ST_SUM      = 4'd11;
   localparam logic [3:0] ST_FINISH   = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.cell_idx = idx_ff;
      cmd.mul_sel  = sqtu_pkg::MUL_SEL_NEXT;
      req_ready    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               idx_in       = sqtu_pkg::CELL_STATE;
               state_in     = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (status.div_done) begin
               state_in = ST_CELL;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_CELL: begin
            cmd.cell_store = 1'b1;
            if (idx_ff == sqtu_pkg::CELL_NEXT_ACTION) begin
               state_in = ST_RD_NEXT;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_DIV_LOAD;
            end
         end
         ST_RD_NEXT: begin
            state_in = ST_RD_HERE;
         end
         ST_RD_HERE: begin
            cmd.rd_here = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = sqtu_pkg::MUL_SEL_NEXT;
            state_in    = ST_TARGET;
         end
         ST_TARGET: begin
            cmd.target_en = 1'b1;
            state_in      = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff_en = 1'b1;
            state_in    = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = sqtu_pkg::MUL_SEL_LO;
            state_in    = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = sqtu_pkg::MUL_SEL_HI;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= sqtu_pkg::CELL_STATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/sqtu_dp.sv =====
// Datapath: fine-index divider, coarse mapping, shared multiplier and result register.
module sqtu_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sqtu_pkg::cfg_type                     cfg,
   input  sqtu_pkg::cmd_type                     cmd,
   output sqtu_pkg::status_type                  status,
   input  logic [sqtu_pkg::FINE_W-1:0]           req_state_cell,
   input  logic [sqtu_pkg::FINE_W-1:0]           req_action_cell,
   input  logic [sqtu_pkg::FINE_W-1:0]           req_next_state_cell,
   input  logic [sqtu_pkg::FINE_W-1:0]           req_next_action_cell,
   input  logic signed [sqtu_pkg::VALUE_W-1:0]   req_reward_value,
   output logic                                  ram_we,
   output logic [sqtu_pkg::ADDR_W-1:0]           ram_waddr,
   output logic [sqtu_pkg::VALUE_W-1:0]          ram_wdata,
   output logic [sqtu_pkg::ADDR_W-1:0]           ram_raddr,
   input  logic [sqtu_pkg::VALUE_W-1:0]          ram_rdata,
   output logic signed [sqtu_pkg::VALUE_W-1:0]   rsp_updated_value,
   output logic [sqtu_pkg::OUT_CELL_W-1:0]       rsp_coarse_state,
   output logic [sqtu_pkg::OUT_CELL_W-1:0]       rsp_coarse_action
);

   // Latched transaction.
   logic [sqtu_pkg::FINE_W-1:0]         fine_ff [4];
   logic signed [sqtu_pkg::VALUE_W-1:0] reward_ff;

   // Scale factors derived from the grid registers.
   logic [sqtu_pkg::SIZE_W-1:0]       fw_eff_ff, sw_ff, sh_ff;
   logic [sqtu_pkg::SCALE_PROD_W-1:0] sw_prod, sh_prod;
   logic [sqtu_pkg::SIZE_W-1:0]       sw_raw, sh_raw;

   // Restoring divider, one quotient bit per step.
   logic [sqtu_pkg::FINE_W-1:0]    quo_ff;
   logic [sqtu_pkg::SIZE_W-1:0]    rem_ff;
   logic [sqtu_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [sqtu_pkg::SIZE_W:0]      trial, trial_sub;
   logic                           trial_ge;

   // Coarse mapping.
   logic [sqtu_pkg::CSIDE_W-1:0] row_c, col_c;
   logic [15:0]                  row_thr, col_thr;
   logic [sqtu_pkg::CELL_W-1:0]  cell_val;
   logic [sqtu_pkg::CELL_W-1:0]  cell_ff [4];
   logic [sqtu_pkg::ADDR_W-1:0]  here_addr, there_addr;

   // Clearing pass.
   logic [sqtu_pkg::ADDR_W-1:0] clr_cnt_ff;

   // Arithmetic.
   logic signed [sqtu_pkg::MUL_A_W-1:0]  mul_a;
   logic [sqtu_pkg::RATE_W-1:0]          mul_b;
   logic signed [sqtu_pkg::MUL_W-1:0]    mul_prod, mul_ff, rnd_next;
   logic signed [sqtu_pkg::VALUE_W-1:0]  predict_ff;
   logic signed [sqtu_pkg::DIFF_W-1:0]   target_wide;
   logic signed [sqtu_pkg::TARGET_W-1:0] target_ff;
   logic signed [sqtu_pkg::DIFF_W-1:0]   diff_in, diff_ff;
   logic [sqtu_pkg::LO_PROD_W-1:0]       lo_ff;
   logic signed [sqtu_pkg::FULL_W-1:0]   full;
   logic signed [sqtu_pkg::ROUND_W-1:0]  round_ff;
   logic signed [sqtu_pkg::NV_W-1:0]     nv;
   logic [sqtu_pkg::VALUE_W-1:0]         nv_sat;

   // Result register.
   logic [sqtu_pkg::VALUE_W-1:0]    out_value_ff;
   logic [sqtu_pkg::OUT_CELL_W-1:0] out_state_ff, out_action_ff;

   always_comb begin
      sw_prod = sqtu_pkg::SCALE_PROD_W'(cfg.fine_width)
              * sqtu_pkg::SCALE_PROD_W'(sqtu_pkg::RECIP);
      sh_prod = sqtu_pkg::SCALE_PROD_W'(cfg.fine_height)
              * sqtu_pkg::SCALE_PROD_W'(sqtu_pkg::RECIP);
      sw_raw  = sw_prod[sqtu_pkg::RECIP_SHIFT +: sqtu_pkg::SIZE_W];
      sh_raw  = sh_prod[sqtu_pkg::RECIP_SHIFT +: sqtu_pkg::SIZE_W];
   end

   always_comb begin
      trial     = {rem_ff, quo_ff[sqtu_pkg::FINE_W-1]};
      trial_sub = trial - {1'b0, fw_eff_ff};
      trial_ge  = trial >= {1'b0, fw_eff_ff};
   end

   // Row and column scaled down by counting the thresholds they reach,
   // which also saturates them at the last coarse row or column.
   always_comb begin
      row_c   = '0;
      col_c   = '0;
      row_thr = '0;
      col_thr = '0;
      for (int k = 1; k < sqtu_pkg::COARSE_SIDE; k++) begin
         row_thr = 16'(k) * {9'b0, sh_ff};
         col_thr = 16'(k) * {9'b0, sw_ff};
         if ({4'b0, quo_ff} >= row_thr) begin
            row_c = sqtu_pkg::CSIDE_W'(k);
         end
         if ({9'b0, rem_ff} >= col_thr) begin
            col_c = sqtu_pkg::CSIDE_W'(k);
         end
      end
      cell_val = sqtu_pkg::CELL_W'(32'(row_c) * sqtu_pkg::COARSE_SIDE + 32'(col_c));
   end

   always_comb begin
      here_addr  = sqtu_pkg::ADDR_W'(32'(cell_ff[sqtu_pkg::CELL_STATE]) * sqtu_pkg::CELLS
                 + 32'(cell_ff[sqtu_pkg::CELL_ACTION]));
      there_addr = sqtu_pkg::ADDR_W'(32'(cell_ff[sqtu_pkg::CELL_NEXT_STATE]) * sqtu_pkg::CELLS
                 + 32'(cell_ff[sqtu_pkg::CELL_NEXT_ACTION]));
   end

   always_comb begin
      case (cmd.mul_sel)
         sqtu_pkg::MUL_SEL_NEXT: begin
            mul_a = {ram_rdata[sqtu_pkg::VALUE_W-1], ram_rdata};
            mul_b = cfg.discount;
         end
         sqtu_pkg::MUL_SEL_LO: begin
            mul_a = {16'b0, diff_ff[sqtu_pkg::SPLIT_W-1:0]};
            mul_b = cfg.learn_rate;
         end
         sqtu_pkg::MUL_SEL_HI: begin
            mul_a = {{15{diff_ff[sqtu_pkg::DIFF_W-1]}},
                     diff_ff[sqtu_pkg::DIFF_W-1:sqtu_pkg::SPLIT_W]};
            mul_b = cfg.learn_rate;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_prod = mul_a * $signed({1'b0, mul_b});
   end

   always_comb begin
      // Products are brought back from Q.32 to Q.16 by adding one half and flooring.
      rnd_next    = mul_ff + 51'sd32768;
      target_wide = $signed(rnd_next[sqtu_pkg::MUL_W-1:16])
                  + $signed({{3{reward_ff[sqtu_pkg::VALUE_W-1]}}, reward_ff});
      diff_in     = $signed({target_ff[sqtu_pkg::TARGET_W-1], target_ff})
                  - $signed({{3{predict_ff[sqtu_pkg::VALUE_W-1]}}, predict_ff});
      full        = $signed({mul_ff[sqtu_pkg::HI_PROD_W-1:0], 17'b0})
                  + $signed({19'b0, lo_ff})
                  + 53'sd32768;
      nv          = $signed({round_ff[sqtu_pkg::ROUND_W-1], round_ff})
                  + $signed({{6{predict_ff[sqtu_pkg::VALUE_W-1]}}, predict_ff});
      if ((&nv[sqtu_pkg::NV_W-1:31]) || !(|nv[sqtu_pkg::NV_W-1:31])) begin
         nv_sat = nv[sqtu_pkg::VALUE_W-1:0];
      end else if (nv[sqtu_pkg::NV_W-1]) begin
         nv_sat = 32'h8000_0000;
      end else begin
         nv_sat = 32'h7FFF_FFFF;
      end
   end

   always_comb begin
      ram_we    = cmd.clr_step || cmd.commit;
      ram_waddr = cmd.clr_step ? clr_cnt_ff : here_addr;
      ram_wdata = cmd.clr_step ? '0 : nv_sat;
      ram_raddr = cmd.rd_here ? here_addr : there_addr;
   end

   assign status.clr_last = clr_cnt_ff == sqtu_pkg::ADDR_W'(sqtu_pkg::DEPTH - 1);
   assign status.div_done = div_cnt_ff == sqtu_pkg::DIV_CNT_W'(sqtu_pkg::FINE_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         div_cnt_ff <= '0;
      end else begin
         if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + sqtu_pkg::ADDR_W'(1);
         end
         if (cmd.div_load) begin
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + sqtu_pkg::DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      fw_eff_ff <= (cfg.fine_width == '0) ? sqtu_pkg::SIZE_W'(1) : cfg.fine_width;
      sw_ff     <= (sw_raw == '0) ? sqtu_pkg::SIZE_W'(1) : sw_raw;
      sh_ff     <= (sh_raw == '0) ? sqtu_pkg::SIZE_W'(1) : sh_raw;

      if (cmd.req_load) begin
         fine_ff[sqtu_pkg::CELL_STATE]       <= req_state_cell;
         fine_ff[sqtu_pkg::CELL_ACTION]      <= req_action_cell;
         fine_ff[sqtu_pkg::CELL_NEXT_STATE]  <= req_next_state_cell;
         fine_ff[sqtu_pkg::CELL_NEXT_ACTION] <= req_next_action_cell;
         reward_ff                           <= req_reward_value;
      end

      if (cmd.div_load) begin
         quo_ff <= fine_ff[cmd.cell_idx];
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[sqtu_pkg::FINE_W-2:0], trial_ge};
         rem_ff <= trial_ge ? trial_sub[sqtu_pkg::SIZE_W-1:0] : trial[sqtu_pkg::SIZE_W-1:0];
      end

      if (cmd.cell_store) begin
         cell_ff[cmd.cell_idx] <= cell_val;
      end

      if (cmd.mul_en) begin
         mul_ff <= mul_prod;
      end
      if (cmd.mul_en && (cmd.mul_sel == sqtu_pkg::MUL_SEL_HI)) begin
         lo_ff <= mul_ff[sqtu_pkg::LO_PROD_W-1:0];
      end
      if (cmd.target_en) begin
         predict_ff <= ram_rdata;
         target_ff  <= target_wide[sqtu_pkg::TARGET_W-1:0];
      end
      if (cmd.diff_en) begin
         diff_ff <= diff_in;
      end
      if (cmd.sum_en) begin
         round_ff <= full[sqtu_pkg::FULL_W-1:16];
      end

      if (cmd.commit) begin
         out_value_ff  <= nv_sat;
         out_state_ff  <= sqtu_pkg::out_cell(cell_ff[sqtu_pkg::CELL_STATE]);
         out_action_ff <= sqtu_pkg::out_cell(cell_ff[sqtu_pkg::CELL_ACTION]);
      end
   end

   assign rsp_updated_value = out_value_ff;
   assign rsp_coarse_state  = out_state_ff;
   assign rsp_coarse_action = out_action_ff;

endmodule

// ===== rtl/sarsa_q_table_update.sv =====
// Top level of the SARSA value-table update block: registers, controller, datapath, table.
//
//   Channel   Direction  Handshake          Payload
//   req       in         req_valid/ready    four fine cell indices, reward (Q16.16)
//   rsp       out        rsp_valid/ready    new table value (Q16.16), coarse state/action
//   csr       in/out     psel/penable       learning rate, discount, fine grid size
//
// Each transaction runs to completion before the next one is accepted: four
// fine indices go one after another through a restoring divider that yields one
// quotient bit per cycle, then two table reads, three passes through the shared
// multiplier and the final saturating add complete the update.
// After reset the table is cleared one entry per cycle, all 625 entries, during which
// no transaction is accepted; register writes are taken at any time.
// A stalled result holds in the output register; the next request is taken
// meanwhile and only its final write waits for the output to drain.
module sarsa_q_table_update (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sqtu_pkg::FINE_W-1:0]           req_state_cell,
   input  logic [sqtu_pkg::FINE_W-1:0]           req_action_cell,
   input  logic [sqtu_pkg::FINE_W-1:0]           req_next_state_cell,
   input  logic [sqtu_pkg::FINE_W-1:0]           req_next_action_cell,
   input  logic signed [sqtu_pkg::VALUE_W-1:0]   req_reward_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [sqtu_pkg::VALUE_W-1:0]   rsp_updated_value,
   output logic [sqtu_pkg::OUT_CELL_W-1:0]       rsp_coarse_state,
   output logic [sqtu_pkg::OUT_CELL_W-1:0]       rsp_coarse_action,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [sqtu_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [sqtu_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [sqtu_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

`include "sarsa_q_table_update_macros.svh"

   // Configuration registers. The register index is the word address.
   logic [sqtu_pkg::RATE_W-1:0] learn_rate_ff, learn_rate_in;
   logic [sqtu_pkg::RATE_W-1:0] discount_ff, discount_in;
   logic [sqtu_pkg::SIZE_W-1:0] fine_width_ff, fine_width_in;
   logic [sqtu_pkg::SIZE_W-1:0] fine_height_ff, fine_height_in;
   logic                        csr_write;
   logic [1:0]                  csr_index;

   sqtu_pkg::cfg_type    cfg;
   sqtu_pkg::cmd_type    cmd;
   sqtu_pkg::status_type status;

   // Table port signals between the datapath and the memory.
   logic                           ram_we;
   logic [sqtu_pkg::ADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [sqtu_pkg::VALUE_W-1:0]   ram_wdata, ram_rdata;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   // A write lands at the access phase; the bits above each register's width are dropped.
   always_comb begin
      learn_rate_in  = learn_rate_ff;
      discount_in    = discount_ff;
      fine_width_in  = fine_width_ff;
      fine_height_in = fine_height_ff;
      if (csr_write) begin
         case (csr_index)
            sqtu_pkg::REG_LEARN_RATE:  learn_rate_in  = pwdata[sqtu_pkg::RATE_W-1:0];
            sqtu_pkg::REG_DISCOUNT:    discount_in    = pwdata[sqtu_pkg::RATE_W-1:0];
            sqtu_pkg::REG_FINE_WIDTH:  fine_width_in  = pwdata[sqtu_pkg::SIZE_W-1:0];
            sqtu_pkg::REG_FINE_HEIGHT: fine_height_in = pwdata[sqtu_pkg::SIZE_W-1:0];
            default: begin
               learn_rate_in = learn_rate_ff;
            end
         endcase
      end
   end

   // Read data is combinational and zero-extended to the bus width.
   always_comb begin
      case (csr_index)
         sqtu_pkg::REG_LEARN_RATE:  prdata = sqtu_pkg::CSR_DATA_W'(learn_rate_ff);
         sqtu_pkg::REG_DISCOUNT:    prdata = sqtu_pkg::CSR_DATA_W'(discount_ff);
         sqtu_pkg::REG_FINE_WIDTH:  prdata = sqtu_pkg::CSR_DATA_W'(fine_width_ff);
         sqtu_pkg::REG_FINE_HEIGHT: prdata = sqtu_pkg::CSR_DATA_W'(fine_height_ff);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff  <= sqtu_pkg::LEARN_RATE_RST;
         discount_ff    <= sqtu_pkg::DISCOUNT_RST;
         fine_width_ff  <= sqtu_pkg::FINE_WIDTH_RST;
         fine_height_ff <= sqtu_pkg::FINE_HEIGHT_RST;
      end else begin
         learn_rate_ff  <= learn_rate_in;
         discount_ff    <= discount_in;
         fine_width_ff  <= fine_width_in;
         fine_height_ff <= fine_height_in;
      end
   end

   always_comb begin
      cfg.learn_rate  = learn_rate_ff;
      cfg.discount    = discount_ff;
      cfg.fine_width  = fine_width_ff;
      cfg.fine_height = fine_height_ff;
   end

   // The controller owns the handshakes and the sequence of each update.
   sqtu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the transaction, the divider, the multiplier and the result.
   sqtu_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .cmd                  (cmd),
      .status               (status),
      .req_state_cell       (req_state_cell),
      .req_action_cell      (req_action_cell),
      .req_next_state_cell  (req_next_state_cell),
      .req_next_action_cell (req_next_action_cell),
      .req_reward_value     (req_reward_value),
      .ram_we               (ram_we),
      .ram_waddr            (ram_waddr),
      .ram_wdata            (ram_wdata),
      .ram_raddr            (ram_raddr),
      .ram_rdata            (ram_rdata),
      .rsp_updated_value    (rsp_updated_value),
      .rsp_coarse_state     (rsp_coarse_state),
      .rsp_coarse_action    (rsp_coarse_action)
   );

   // Value table, one entry per coarse state and coarse action.
   sqtu_ram #(
      .WIDTH (sqtu_pkg::VALUE_W),
      .DEPTH (sqtu_pkg::DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // No transaction is taken while the table is still being cleared.
   `SQTU_ASSERT(a_no_accept_in_clear, !(cmd.clr_step && req_ready), "request accepted during table clear")
   // A new result is never written over one that is still waiting.
   `SQTU_ASSERT(a_commit_out_free, !cmd.commit || !rsp_valid || rsp_ready, "result overwritten")
   // A committed update shows up on the result channel in the next cycle.
   `SQTU_ASSERT_NEXT(a_commit_shows, cmd.commit, rsp_valid, "committed result not presented")
   // Only one update is in progress at a time.
   `SQTU_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "second request taken")

endmodule
